### src/phdr_pkg.sv
// ----------------------------------------------------------------------------
// phdr_pkg
// Shared types, codes and constants of the pH dosing regulator.
// ----------------------------------------------------------------------------
`default_nettype none

package phdr_pkg;

  // Event codes
  localparam logic [1:0] OP_READING  = 2'd0;
  localparam logic [1:0] OP_NO_REPLY = 2'd1;
  localparam logic [1:0] OP_HOST     = 2'd2;
  localparam logic [1:0] OP_START    = 2'd3;

  // Dosing modes
  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_ACID   = 2'd1;
  localparam logic [1:0] MODE_ALKALI = 2'd2;

  // Sticky error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_RANGE   = 2'd1;
  localparam logic [1:0] ERR_TIMEOUT = 2'd2;
  localparam logic [1:0] ERR_SWING   = 2'd3;

  // Register map
  localparam int PADDR_W   = 5;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DOSE_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_OFFSET   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_S     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DOSE_TIMEOUT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HOST_TIMEOUT = 3'd6;

  // Register reset values
  localparam logic [13:0] TARGET_RST       = 14'd7000;
  localparam logic [15:0] GAIN_RST         = 16'd4096;
  localparam logic [7:0]  SETTLE_RST       = 8'd10;
  localparam logic [31:0] DOSE_TIMEOUT_RST = 32'd600000;
  localparam logic [31:0] HOST_TIMEOUT_RST = 32'd60000;

  // Calibration: gain scaled by 2^CAL_SHIFT, rounded
  localparam int CAL_SHIFT = 12;
  localparam int CAL_ROUND = 2048;
  localparam int CAL_W     = 22;

  // Sensor window and swing limit in milli-pH, and event count limits
  localparam int RAW_HI      = 14000;
  localparam int SWING_LIM   = 1000;
  localparam int RANGE_LIMIT = 3;
  localparam int SWING_LIMIT = 3;
  localparam int MISS_LIMIT  = 5;

  // Dosing bands and pulses
  localparam int BAND_FINE   = 50;
  localparam int BAND_MID    = 100;
  localparam int BAND_COARSE = 200;
  localparam int PUMP_FINE   = 500;
  localparam int PUMP_MID    = 1000;
  localparam int PUMP_COARSE = 2000;
  localparam int PUMP_TOP    = 3000;
  localparam int TOP_WAIT_MS = 5000;
  localparam int MS_PER_S    = 1000;

  // Queue depth defaults
  localparam int MID_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF = 2;

  typedef struct packed {
    logic [1:0]         dose_mode;
    logic [13:0]        setpoint_mph;
    logic signed [15:0] cal_gain;
    logic signed [15:0] cal_offset;
    logic [7:0]         settle_seconds;
    logic [31:0]        dose_timeout_ms;
    logic [31:0]        host_timeout_ms;
  } cfg_t;

  // Classified event between front and back
  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] cal;
    logic [31:0]        now_ms;
    logic               out_of_range;
  } item_t;

  typedef struct packed {
    logic [11:0]        pump_ms;
    logic [17:0]        wait_ms;
    logic signed [15:0] ph_report;
    logic               control_on;
    logic [1:0]         error_kind;
    logic               link_fault;
  } res_t;

endpackage

`default_nettype wire

### src/phdr_fifo.sv
// ----------------------------------------------------------------------------
// phdr_fifo
// Small register queue with show-ahead read, used between the stages.
// ----------------------------------------------------------------------------
`default_nettype none

module phdr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // store the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

### src/phdr_front.sv
// ----------------------------------------------------------------------------
// phdr_front
// Accepts events, multiplies the reading by the gain and calibrates it.
// ----------------------------------------------------------------------------
`default_nettype none

module phdr_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire phdr_pkg::cfg_t cfg,
  input  wire logic           push,
  output logic                full,
  input  wire logic [1:0]     operation,
  input  wire logic [15:0]    raw_ph,
  input  wire logic [31:0]    now_ms,
  output logic                out_valid,
  input  wire logic           out_ready,
  output phdr_pkg::item_t     out_item
);

  import phdr_pkg::*;

  localparam int PROD_W = 33;
  localparam int SUM_W  = PROD_W + 1;

  logic                     f_valid;
  logic [1:0]               f_op;
  logic signed [PROD_W-1:0] f_prod;
  logic [31:0]              f_now;
  logic                     f_oor;
  logic                     ready;
  logic signed [SUM_W-1:0]  rounded;
  logic signed [CAL_W-1:0]  scaled;
  logic signed [CAL_W-1:0]  cal_wide;
  logic signed [15:0]       cal_sat;

  assign ready = !f_valid || out_ready;
  assign full  = !ready;

  // take a beat and register the product
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (ready) begin
      f_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && push) begin
      f_op   <= operation;
      f_prod <= cfg.cal_gain * $signed({1'b0, raw_ph});
      f_now  <= now_ms;
      f_oor  <= (raw_ph == '0) || (raw_ph >= 16'(RAW_HI));
    end
  end

  // round, floor-shift, add offset, saturate to 16 bits
  assign rounded  = SUM_W'(f_prod) + $signed(SUM_W'(CAL_ROUND));
  assign scaled   = rounded[SUM_W-1:CAL_SHIFT];
  assign cal_wide = scaled + CAL_W'(cfg.cal_offset);

  always_comb begin
    if (cal_wide > $signed(CAL_W'(32767))) begin
      cal_sat = 16'sh7FFF;
    end else if (cal_wide < -$signed(CAL_W'(32768))) begin
      cal_sat = 16'sh8000;
    end else begin
      cal_sat = cal_wide[15:0];
    end
  end

  assign out_valid             = f_valid;
  assign out_item.op           = f_op;
  assign out_item.cal          = cal_sat;
  assign out_item.now_ms       = f_now;
  assign out_item.out_of_range = f_oor;

endmodule

`default_nettype wire

### src/phdr_back.sv
// ----------------------------------------------------------------------------
// phdr_back
// Control state: timeouts, range and swing checks, band choice, link fault.
// ----------------------------------------------------------------------------
`default_nettype none

module phdr_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire phdr_pkg::cfg_t  cfg,
  input  wire logic            in_valid,
  input  wire phdr_pkg::item_t in_item,
  output logic                 in_pop,
  input  wire logic            out_full,
  output logic                 out_push,
  output phdr_pkg::res_t       out_res
);

  import phdr_pkg::*;

  // state
  logic               active,       active_next;
  logic               timing_on,    timing_on_next;
  logic [31:0]        dose_start,   dose_start_next;
  logic [31:0]        last_contact, last_contact_next;
  logic               base_valid,   base_valid_next;
  logic signed [15:0] base_ph,      base_ph_next;
  logic [1:0]         swing_count,  swing_count_next;
  logic [1:0]         range_count,  range_count_next;
  logic [2:0]         miss_count,   miss_count_next;
  logic [1:0]         error_reg,    error_reg_next;

  logic               fire;
  logic               stop_req;
  logic               skip;
  logic               silent;
  logic               dose_late;
  logic signed [15:0] base_sel;
  logic [1:0]         swing_sel;
  logic signed [16:0] dev;
  logic signed [16:0] ph_gap;
  logic               dosing;
  logic               bad;
  logic [11:0]        pump;
  logic [17:0]        top_wait;
  logic [17:0]        settle_ms;
  logic signed [15:0] report;
  logic               link;

  assign fire     = in_valid && !out_full;
  assign in_pop   = fire;
  assign out_push = fire;

  // timers, modulo 2^32
  assign silent    = (in_item.now_ms - last_contact) > cfg.host_timeout_ms;
  assign dose_late = (in_item.now_ms - dose_start) > cfg.dose_timeout_ms;

  // swing check against the base, loaded from this reading if none held
  assign base_sel  = base_valid ? base_ph : in_item.cal;
  assign swing_sel = base_valid ? swing_count : 2'd0;
  assign dev       = 17'(in_item.cal) - 17'(base_sel);
  assign bad       = ((cfg.dose_mode == MODE_ACID) && (dev >= $signed(17'(SWING_LIM))))
                  || ((cfg.dose_mode == MODE_ALKALI) && (dev <= -$signed(17'(SWING_LIM))));
  assign dosing    = (cfg.dose_mode == MODE_ACID) || (cfg.dose_mode == MODE_ALKALI);

  // distance to target in the dosing direction
  assign ph_gap = (cfg.dose_mode == MODE_ACID)
                ? 17'(in_item.cal) - $signed({3'b000, cfg.setpoint_mph})
                : $signed({3'b000, cfg.setpoint_mph}) - 17'(in_item.cal);

  // pick the pulse band
  always_comb begin
    top_wait = '0;
    if (ph_gap <= 17'sd0) begin
      pump = '0;
    end else if (ph_gap <= $signed(17'(BAND_FINE))) begin
      pump = 12'(PUMP_FINE);
    end else if (ph_gap <= $signed(17'(BAND_MID))) begin
      pump = 12'(PUMP_MID);
    end else if (ph_gap <= $signed(17'(BAND_COARSE))) begin
      pump = 12'(PUMP_COARSE);
    end else begin
      pump     = 12'(PUMP_TOP);
      top_wait = 18'(TOP_WAIT_MS);
    end
  end

  assign settle_ms = 18'(cfg.settle_seconds) * 18'(MS_PER_S);

  // step the control state for one event
  always_comb begin
    active_next       = active;
    timing_on_next    = timing_on;
    dose_start_next   = dose_start;
    last_contact_next = last_contact;
    base_valid_next   = base_valid;
    base_ph_next      = base_ph;
    swing_count_next  = swing_count;
    range_count_next  = range_count;
    miss_count_next   = miss_count;
    error_reg_next    = error_reg;
    stop_req          = 1'b0;
    skip              = 1'b0;
    report            = '0;
    link              = 1'b0;
    out_res.pump_ms   = '0;
    out_res.wait_ms   = '0;

    unique case (in_item.op)
      OP_READING: begin
        if (!active) begin
          report          = in_item.cal;
          miss_count_next = '0;
        end else if (silent) begin
          stop_req = 1'b1;
        end else begin
          miss_count_next = '0;
          report          = in_item.cal;
          if (in_item.out_of_range) begin
            if (range_count >= 2'(RANGE_LIMIT - 1)) begin
              error_reg_next   = ERR_RANGE;
              stop_req         = 1'b1;
              range_count_next = '0;
              skip             = 1'b1;
            end else begin
              range_count_next = range_count + 1'b1;
            end
          end else begin
            range_count_next = '0;
          end
          if (!skip) begin
            base_valid_next = 1'b1;
            if (bad) begin
              base_ph_next = base_sel;
              if (swing_sel >= 2'(SWING_LIMIT - 1)) begin
                error_reg_next = ERR_SWING;
                stop_req       = 1'b1;
              end else begin
                swing_count_next = swing_sel + 1'b1;
              end
            end else begin
              base_ph_next     = in_item.cal;
              swing_count_next = '0;
              if (dosing) begin
                out_res.pump_ms = pump;
                out_res.wait_ms = top_wait + settle_ms;
                if (pump == '0) begin
                  timing_on_next = 1'b0;
                end else if (!timing_on) begin
                  dose_start_next = in_item.now_ms;
                  timing_on_next  = 1'b1;
                end else if (dose_late) begin
                  error_reg_next = ERR_TIMEOUT;
                  stop_req       = 1'b1;
                end
              end
            end
          end
        end
      end
      OP_NO_REPLY: begin
        if (active && silent) begin
          stop_req = 1'b1;
        end else if (miss_count >= 3'(MISS_LIMIT - 1)) begin
          miss_count_next = '0;
          link            = 1'b1;
        end else begin
          miss_count_next = miss_count + 1'b1;
        end
      end
      OP_HOST: begin
        last_contact_next = in_item.now_ms;
      end
      OP_START: begin
        active_next       = 1'b1;
        base_valid_next   = 1'b0;
        last_contact_next = in_item.now_ms;
      end
      default: begin
      end
    endcase

    // drop control on any stop condition
    if (stop_req) begin
      active_next      = 1'b0;
      timing_on_next   = 1'b0;
      base_valid_next  = 1'b0;
      swing_count_next = '0;
    end

    out_res.ph_report  = report;
    out_res.control_on = active_next;
    out_res.error_kind = error_reg_next;
    out_res.link_fault = link;
  end

  // hold state, advance on each beat
  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      timing_on    <= 1'b0;
      dose_start   <= '0;
      last_contact <= '0;
      base_valid   <= 1'b0;
      base_ph      <= '0;
      swing_count  <= '0;
      range_count  <= '0;
      miss_count   <= '0;
      error_reg    <= ERR_NONE;
    end else if (fire) begin
      active       <= active_next;
      timing_on    <= timing_on_next;
      dose_start   <= dose_start_next;
      last_contact <= last_contact_next;
      base_valid   <= base_valid_next;
      base_ph      <= base_ph_next;
      swing_count  <= swing_count_next;
      range_count  <= range_count_next;
      miss_count   <= miss_count_next;
      error_reg    <= error_reg_next;
    end
  end

`ifndef SYNTH
  // an error, once raised, stays until reset
  assert property (@(posedge clk) disable iff (rst)
    (error_reg != ERR_NONE) |=> (error_reg != ERR_NONE))
    else $error("phdr_back: sticky error cleared");

  // the dosing timer only runs under active control
  assert property (@(posedge clk) disable iff (rst) timing_on |-> active)
    else $error("phdr_back: dosing timer running while inactive");

  // counters wrap or stop before their limits
  assert property (@(posedge clk) disable iff (rst)
    (miss_count < 3'(MISS_LIMIT)) && (range_count < 2'(RANGE_LIMIT))
    && (swing_count < 2'(SWING_LIMIT)))
    else $error("phdr_back: event counter reached its limit");

  // a link fault comes only from a missed reply
  assert property (@(posedge clk) disable iff (rst)
    (out_push && out_res.link_fault) |-> (in_item.op == OP_NO_REPLY))
    else $error("phdr_back: link fault on wrong event");
`endif

endmodule

`default_nettype wire

### src/ph_dosing_regulator_top.sv
// ----------------------------------------------------------------------------
// ph_dosing_regulator_top
// pH dosing regulator: event front end, control back end, register port.
// ----------------------------------------------------------------------------
// Takes one event per clock while full is low and returns one result per
// event, in order. An accepted event is registered with the gain product in
// the front stage, calibrated into a short queue, then handled by the
// combinational control step of the back end, whose result enters an output
// queue: the front register, the middle queue and the output queue lie
// between an event and its result. Sustained rate is one event per cycle when
// nothing stalls. Write the registers only while no result is pending.
`default_nettype none

module ph_dosing_regulator_top #(
  parameter int MID_DEPTH = phdr_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH = phdr_pkg::OUT_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // event queue side
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [1:0]                   operation,
  input  wire logic [15:0]                  raw_ph,
  input  wire logic [31:0]                  now_ms,
  // result queue side
  output logic                              empty,
  input  wire logic                         pop,
  output logic [11:0]                       pump_ms,
  output logic [17:0]                       wait_ms,
  output logic signed [15:0]                ph_report,
  output logic                              control_on,
  output logic [1:0]                        error_kind,
  output logic                              link_fault,
  // register port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [phdr_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  import phdr_pkg::*;

  localparam int ITEM_W = $bits(item_t);
  localparam int RES_W  = $bits(res_t);

  cfg_t                   cfg;
  logic                   cfg_wr;
  logic [CFG_IDX_W-1:0]   cfg_idx;
  logic                   front_valid;
  logic                   front_ready;
  item_t                  front_item;
  logic                   mid_full;
  logic                   mid_empty;
  logic                   mid_pop;
  logic [ITEM_W-1:0]      mid_rdata;
  item_t                  mid_item;
  logic                   out_full;
  logic                   out_push;
  res_t                   back_res;
  logic [RES_W-1:0]       out_rdata;
  res_t                   head;

  // register writes on the access beat
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dose_mode       <= MODE_NONE;
      cfg.setpoint_mph    <= TARGET_RST;
      cfg.cal_gain        <= GAIN_RST;
      cfg.cal_offset      <= '0;
      cfg.settle_seconds  <= SETTLE_RST;
      cfg.dose_timeout_ms <= DOSE_TIMEOUT_RST;
      cfg.host_timeout_ms <= HOST_TIMEOUT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DOSE_MODE:    cfg.dose_mode       <= pwdata[1:0];
        REG_SETPOINT:     cfg.setpoint_mph    <= pwdata[13:0];
        REG_CAL_GAIN:     cfg.cal_gain        <= pwdata[15:0];
        REG_CAL_OFFSET:   cfg.cal_offset      <= pwdata[15:0];
        REG_SETTLE_S:     cfg.settle_seconds  <= pwdata[7:0];
        REG_DOSE_TIMEOUT: cfg.dose_timeout_ms <= pwdata;
        REG_HOST_TIMEOUT: cfg.host_timeout_ms <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (cfg_idx)
      REG_DOSE_MODE:    prdata = 32'(cfg.dose_mode);
      REG_SETPOINT:     prdata = 32'(cfg.setpoint_mph);
      REG_CAL_GAIN:     prdata = {16'h0000, cfg.cal_gain};
      REG_CAL_OFFSET:   prdata = {16'h0000, cfg.cal_offset};
      REG_SETTLE_S:     prdata = 32'(cfg.settle_seconds);
      REG_DOSE_TIMEOUT: prdata = cfg.dose_timeout_ms;
      REG_HOST_TIMEOUT: prdata = cfg.host_timeout_ms;
      default:          prdata = '0;
    endcase
  end

  phdr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .full      (full),
    .operation (operation),
    .raw_ph    (raw_ph),
    .now_ms    (now_ms),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_item  (front_item)
  );

  assign front_ready = !mid_full;

  phdr_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .wdata (front_item),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  assign mid_item = mid_rdata;

  phdr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (!mid_empty),
    .in_item  (mid_item),
    .in_pop   (mid_pop),
    .out_full (out_full),
    .out_push (out_push),
    .out_res  (back_res)
  );

  phdr_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (back_res),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  // present the oldest result
  assign head       = out_rdata;
  assign pump_ms    = head.pump_ms;
  assign wait_ms    = head.wait_ms;
  assign ph_report  = head.ph_report;
  assign control_on = head.control_on;
  assign error_kind = head.error_kind;
  assign link_fault = head.link_fault;

endmodule

`default_nettype wire
